>>> hdl/nbd_pkg.sv
// Package for the node identifier decoder: field widths, layout and status
// codes, and the item types shared by the interfaces and the modules.
// Depends on nothing.
`default_nettype none

package nbd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned StatW  = 2;
  localparam int unsigned NsW    = 16;
  localparam int unsigned IdW    = 32;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned KindW  = 2;

  // The low nibble of the mask byte selects the layout.
  localparam logic [ByteW-1:0] FMT_MASK = 8'h0F;

  localparam logic [KindW-1:0] FMT_TWOBYTE  = 2'd0;
  localparam logic [KindW-1:0] FMT_FOURBYTE = 2'd1;
  localparam logic [KindW-1:0] FMT_NUMERIC  = 2'd2;
  localparam logic [KindW-1:0] FMT_STRING   = 2'd3;

  localparam logic [StatW-1:0] ST_GOOD   = 2'd0;
  localparam logic [StatW-1:0] ST_BADFMT = 2'd1;
  localparam logic [StatW-1:0] ST_TRUNC  = 2'd2;

  // Byte phase zero means the next byte is a mask byte.
  localparam logic [PhaseW-1:0] PH_MASK = 3'd0;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_buffer;
  } nbd_in_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic             id_is_string;
    logic [NsW-1:0]   ns_index;
    logic [IdW-1:0]   numeric_id;
  } nbd_out_t;

  // Number of bytes after the mask that complete each layout.
  function automatic logic [PhaseW-1:0] layout_length(input logic [KindW-1:0] kind);
    logic [PhaseW-1:0] len;
    case (kind)
      FMT_TWOBYTE:  len = 3'd1;
      FMT_FOURBYTE: len = 3'd3;
      FMT_NUMERIC:  len = 3'd6;
      default:      len = 3'd2;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> hdl/nbd_in_if.sv
// Input channel of the node identifier decoder: valid/ready and one byte.
// Depends on nbd_pkg.
`default_nettype none

interface nbd_in_if;
  import nbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

>>> hdl/nbd_out_if.sv
// Result channel of the node identifier decoder: valid/ready and the result.
// Depends on nbd_pkg.
`default_nettype none

interface nbd_out_if;
  import nbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic             id_is_string;
  logic [NsW-1:0]   ns_index;
  logic [IdW-1:0]   numeric_id;

  modport source (output valid, output status, output id_is_string,
                  output ns_index, output numeric_id, input ready);
  modport sink   (input valid, input status, input id_is_string,
                  input ns_index, input numeric_id, output ready);
endinterface

`default_nettype wire

>>> hdl/nbd_parser.sv
// Byte-level parser state of the node identifier decoder: phase, layout,
// and the namespace and identifier accumulators. Depends on nbd_pkg.
`default_nettype none

module nbd_parser (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               step_i,
  input  nbd_pkg::nbd_in_t  in_i,
  output logic              res_valid_o,
  output nbd_pkg::nbd_out_t res_o
);
  import nbd_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [KindW-1:0]  kind_q, kind_d;
  logic [NsW-1:0]    ns_q, ns_d;
  logic [IdW-1:0]    id_q, id_d;

  logic [ByteW-1:0]  fmt;
  logic [NsW-1:0]    ns_upd;
  logic [IdW-1:0]    id_upd;
  logic [NsW-1:0]    b_ns;
  logic [IdW-1:0]    b_id;

  assign fmt  = in_i.data_byte & FMT_MASK;
  assign b_ns = {{(NsW-ByteW){1'b0}}, in_i.data_byte};
  assign b_id = {{(IdW-ByteW){1'b0}}, in_i.data_byte};

  // Accumulator values after folding in one body byte.
  always_comb begin
    ns_upd = ns_q;
    id_upd = id_q;
    case (kind_q)
      FMT_TWOBYTE: begin
        id_upd = b_id;
      end
      FMT_FOURBYTE: begin
        if (phase_q == 3'd1) begin
          ns_upd = b_ns;
        end else if (phase_q == 3'd2) begin
          id_upd = id_q | b_id;
        end else begin
          id_upd = id_q | (b_id << 8);
        end
      end
      FMT_NUMERIC: begin
        case (phase_q)
          3'd1:    ns_upd = ns_q | b_ns;
          3'd2:    ns_upd = ns_q | (b_ns << 8);
          3'd3:    id_upd = id_q | b_id;
          3'd4:    id_upd = id_q | (b_id << 8);
          3'd5:    id_upd = id_q | (b_id << 16);
          3'd6:    id_upd = id_q | (b_id << 24);
          default: id_upd = id_q;
        endcase
      end
      default: begin
        if (phase_q == 3'd1) begin
          ns_upd = ns_q | b_ns;
        end else if (phase_q == 3'd2) begin
          ns_upd = ns_q | (b_ns << 8);
        end
      end
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    kind_d      = kind_q;
    ns_d        = ns_q;
    id_d        = id_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      if (phase_q == PH_MASK) begin
        phase_d = PH_MASK;
        kind_d  = '0;
        ns_d    = '0;
        id_d    = '0;
        if (fmt > {{(ByteW-KindW){1'b0}}, FMT_STRING}) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_BADFMT;
        end else if (in_i.end_of_buffer) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_TRUNC;
        end else begin
          kind_d  = fmt[KindW-1:0];
          phase_d = 3'd1;
        end
      end else if (phase_q >= layout_length(kind_q)) begin
        // The message is complete: report it and start over.
        res_valid_o    = 1'b1;
        res_o.status   = ST_GOOD;
        res_o.ns_index = ns_upd;
        if (kind_q == FMT_STRING) begin
          res_o.id_is_string = 1'b1;
        end else begin
          res_o.numeric_id = id_upd;
        end
        phase_d = PH_MASK;
        kind_d  = '0;
        ns_d    = '0;
        id_d    = '0;
      end else if (in_i.end_of_buffer) begin
        res_valid_o  = 1'b1;
        res_o.status = ST_TRUNC;
        phase_d      = PH_MASK;
        kind_d       = '0;
        ns_d         = '0;
        id_d         = '0;
      end else begin
        phase_d = phase_q + 3'd1;
        ns_d    = ns_upd;
        id_d    = id_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MASK;
      kind_q  <= '0;
      ns_q    <= '0;
      id_q    <= '0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      ns_q    <= ns_d;
      id_q    <= id_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/nodeid_binary_decoder.sv
// Top level of the node identifier decoder: input register, parser and
// result register. Depends on nbd_pkg, nbd_in_if, nbd_out_if, nbd_parser.
`default_nettype none

// The decoder takes one byte of an encoded node identifier per transaction
// and emits at most one result per byte: a good result when the identifier
// (or, for the string layout, the namespace) is complete, an unknown-format
// result for a mask whose low nibble is above three, or a truncation result
// when end_of_buffer marks a byte that does not finish the message. A byte
// can be taken in every clock cycle; the rate is one byte per cycle as long
// as the result side keeps taking results. A byte passes through the input
// register and is parsed once the result register is free; its result, if
// any, is loaded into the result register and held there until taken.
// The input side stalls only while the result register holds a result that
// has not been taken and the byte waiting in the input register must move.
module nodeid_binary_decoder (
  input  wire       clk_i,
  input  wire       rst_ni,
  nbd_in_if.sink    in_i,
  nbd_out_if.source out_o
);
  import nbd_pkg::*;

  // Input register.
  logic     in_valid_q, in_valid_d;
  nbd_in_t  in_data_q, in_data_d;

  // Result register.
  logic     out_valid_q, out_valid_d;
  nbd_out_t out_data_q, out_data_d;

  logic     out_free;
  logic     step;
  logic     res_valid;
  nbd_out_t res;

  // The result register can load when it is empty or being emptied now.
  assign out_free = !out_valid_q || out_o.ready;

  // The byte in the input register is parsed when its result has a place.
  assign step = in_valid_q && out_free;

  // A new byte enters when the input register is empty or moving on.
  assign in_i.ready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    in_data_d  = in_data_q;
    if (in_i.ready) begin
      in_valid_d              = in_i.valid;
      in_data_d.data_byte     = in_i.data_byte;
      in_data_d.end_of_buffer = in_i.end_of_buffer;
    end
  end

  nbd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .in_i        (in_data_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_free) begin
      out_valid_d = step && res_valid;
      out_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_data_q  <= in_data_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_data_q.status;
  assign out_o.id_is_string = out_data_q.id_is_string;
  assign out_o.ns_index     = out_data_q.ns_index;
  assign out_o.numeric_id   = out_data_q.numeric_id;

endmodule

`default_nettype wire

>>> verif/nbd_checker.sv
// Result checker for the node identifier decoder: watches both channels,
// predicts each result from the accepted bytes and compares field by field.
// Depends on nbd_pkg, nbd_in_if and nbd_out_if.
`timescale 1ns / 1ps

module nbd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  nbd_in_if           in_mon,
  nbd_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  import nbd_pkg::*;

  // Predicted decoder state.
  logic [PhaseW-1:0] dec_phase;
  logic [KindW-1:0]  dec_kind;
  logic [NsW-1:0]    dec_ns;
  logic [IdW-1:0]    dec_id;

  nbd_out_t expected_results[$];
  nbd_out_t fresh_result;
  nbd_out_t seen_result;
  nbd_out_t want_result;
  logic     fresh_valid;

  task automatic clear_decoder();
    dec_phase = PH_MASK;
    dec_kind  = FMT_TWOBYTE;
    dec_ns    = '0;
    dec_id    = '0;
  endtask

  // Works out the result, if any, that one accepted byte causes.
  task automatic decode_byte(input logic [ByteW-1:0] b, input logic eob,
                             output logic got, output nbd_out_t res);
    logic [3:0] fmt;
    int         p;
    int         needed;
    got = 1'b0;
    res = '0;
    if (dec_phase == PH_MASK) begin
      fmt = 4'(b & FMT_MASK);
      if (fmt > 4'(FMT_STRING)) begin
        got = 1'b1;
        res.status = ST_BADFMT;
        clear_decoder();
      end else begin
        clear_decoder();
        dec_kind  = fmt[KindW-1:0];
        dec_phase = 3'd1;
        if (eob) begin
          got = 1'b1;
          res.status = ST_TRUNC;
          clear_decoder();
        end
      end
    end else begin
      p = int'(dec_phase);
      case (dec_kind)
        FMT_TWOBYTE: begin
          dec_id = 32'(b);
          needed = 1;
        end
        FMT_FOURBYTE: begin
          if (p == 1) dec_ns[7:0] = b;
          else if (p == 2) dec_id[7:0] = b;
          else dec_id[15:8] = b;
          needed = 3;
        end
        FMT_NUMERIC: begin
          if (p <= 2) dec_ns[8*(p-1) +: 8] = b;
          else if (p <= 6) dec_id[8*(p-3) +: 8] = b;
          needed = 6;
        end
        default: begin
          if (p <= 2) dec_ns[8*(p-1) +: 8] = b;
          needed = 2;
        end
      endcase
      if (p >= needed) begin
        got = 1'b1;
        res.status       = ST_GOOD;
        res.id_is_string = (dec_kind == FMT_STRING);
        res.ns_index     = dec_ns;
        res.numeric_id   = (dec_kind == FMT_STRING) ? '0 : dec_id;
        clear_decoder();
      end else begin
        dec_phase = PH_MASK + PhaseW'(p + 1);
        if (eob) begin
          got = 1'b1;
          res.status = ST_TRUNC;
          clear_decoder();
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [IdW-1:0] got,
                                 input logic [IdW-1:0] want);
    $display("[%0t] result %0d: %s is %0h, predicted %0h",
             $realtime, checked_o, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_decoder();
      expected_results.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        decode_byte(in_mon.data_byte, in_mon.end_of_buffer, fresh_valid, fresh_result);
        if (fresh_valid) expected_results.push_back(fresh_result);
      end
      if (out_mon.valid && out_mon.ready) begin
        seen_result.status       = out_mon.status;
        seen_result.id_is_string = out_mon.id_is_string;
        seen_result.ns_index     = out_mon.ns_index;
        seen_result.numeric_id   = out_mon.numeric_id;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(seen_result.status), '0);
        end else begin
          want_result = expected_results.pop_front();
          if (seen_result.status != want_result.status)
            report_mismatch("status", 32'(seen_result.status), 32'(want_result.status));
          if (seen_result.id_is_string != want_result.id_is_string)
            report_mismatch("id_is_string", 32'(seen_result.id_is_string),
                            32'(want_result.id_is_string));
          if (seen_result.ns_index != want_result.ns_index)
            report_mismatch("ns_index", 32'(seen_result.ns_index),
                            32'(want_result.ns_index));
          if (seen_result.numeric_id != want_result.numeric_id)
            report_mismatch("numeric_id", seen_result.numeric_id, want_result.numeric_id);
        end
        checked_o++;
      end
      pending_o = expected_results.size();
    end
  end

endmodule

>>> verif/tb.sv
// Top of the node identifier decoder testbench: clock, reset, byte stream
// stimulus, result-side pacing and the verdict. Depends on nbd_pkg, the two
// channel interfaces, nodeid_binary_decoder and nbd_checker.
`timescale 1ns / 1ps

module tb;
  import nbd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  // The checker owns prediction and comparison; this module only drives.
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // Pacing switches, changed between phases of the run.
  logic send_idle_on;
  logic recv_idle_on;
  int unsigned bytes_sent;

  nbd_in_if  in_ch ();
  nbd_out_if out_ch ();

  nodeid_binary_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  nbd_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #10 clk_i = ~clk_i;

  // A generous ceiling: even with every gap and stall at its longest the run
  // needs well under a tenth of this.
  initial begin : watchdog
    #5ms;
    $display("timeout with %0d results still outstanding", pending);
    $display("status: fail");
    $finish;
  end

  // Offers one byte and returns at the edge where the transaction happens.
  // The valid line stays high if the next byte follows without a gap, so it
  // is never lowered and raised within the same time step.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic eob);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_buffer <= eob;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Stops offering and waits until every predicted result has been taken.
  // The first edge lets the checker see the last transaction before the
  // count is trusted.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Field values lean toward the extremes so the all-zero and all-one corners
  // come up often next to plain random values.
  function automatic logic [IdW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // One random message. Most are well formed with random contents, some are
  // cut short by end_of_buffer, and the rest are unknown-format masks and
  // loose bytes that land wherever the parser happens to be.
  task automatic send_random_message();
    logic [ByteW-1:0] frame[$];
    logic [ByteW-1:0] mask;
    logic [KindW-1:0] kind;
    logic [NsW-1:0]   ns;
    logic [IdW-1:0]   id;
    int               sel;
    int               cut;
    int               body;
    sel = $urandom_range(0, 9);
    if (sel == 8) begin
      mask = {4'($urandom_range(0, 15)), 4'($urandom_range(4, 15))};
      send_byte(mask, 1'($urandom));
    end else if (sel == 9) begin
      send_byte(8'($urandom), 1'($urandom));
    end else begin
      kind = KindW'(sel % 4);
      ns   = NsW'(pick_value());
      id   = pick_value();
      mask = {4'($urandom_range(0, 15)), 2'b00, kind};
      frame.push_back(mask);
      case (kind)
        FMT_TWOBYTE: frame.push_back(id[7:0]);
        FMT_FOURBYTE: begin
          frame.push_back(ns[7:0]);
          frame.push_back(id[7:0]);
          frame.push_back(id[15:8]);
        end
        FMT_NUMERIC: begin
          frame.push_back(ns[7:0]);
          frame.push_back(ns[15:8]);
          for (int k = 0; k < 4; k++) frame.push_back(id[8*k +: 8]);
        end
        default: begin
          frame.push_back(ns[7:0]);
          frame.push_back(ns[15:8]);
        end
      endcase
      // cut marks the byte that carries end_of_buffer; -1 means none.
      case ($urandom_range(0, 3))
        0:       cut = $urandom_range(0, frame.size() - 2);
        1:       cut = frame.size() - 1;
        default: cut = -1;
      endcase
      for (int k = 0; k < frame.size(); k++) begin
        send_byte(frame[k], k == cut);
        if (k == cut) break;
      end
      // A string body is not parsed by the block, so its bytes are taken as
      // fresh mask bytes; a few of them keep that path exercised.
      if (kind == FMT_STRING && cut < 0) begin
        body = $urandom_range(0, 3);
        repeat (body) send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // Result side: one draw of idle cycles per result, and a single long
  // hold-off after the twenty-fifth result so that the result register and
  // then the input register fill up while bytes keep coming.
  initial begin : result_taker
    int gap;
    int taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = recv_idle_on ? $urandom_range(0, 16) : 0;
      if (taken == 25) gap = 80;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin : stimulus
    logic [ByteW:0] opening[];
    int unsigned    phase_end;
    // Opening sequence, one {byte, end_of_buffer} pair per transaction.
    opening = '{
      // Two-byte layout with the smallest and, ending the buffer on the
      // completing byte, the largest identifier.
      {8'h00, 1'b0}, {8'h00, 1'b0},
      {8'hF0, 1'b0}, {8'hFF, 1'b1},
      // Four-byte layout with every field at its maximum.
      {8'hF1, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},
      // Numeric layout at its maximum, buffer ending on the last byte.
      {8'h02, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},
      {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b1},
      // String layout: the result comes once the namespace is in.
      {8'hA3, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},
      // Unknown formats, the second one with end_of_buffer set.
      {8'h04, 1'b0}, {8'hFF, 1'b1},
      // A valid mask that is also the last byte, then a four-byte message
      // that ends right after its namespace.
      {8'h02, 1'b1},
      {8'h01, 1'b0}, {8'h12, 1'b1}
    };

    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.end_of_buffer <= 1'b0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    bytes_sent   = 0;
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[k]) send_byte(opening[k][ByteW:1], opening[k][0]);

    // Four pacing phases of about 150 bytes each: full rate on both sides
    // (the long result hold-off falls here), both sides idling, only the
    // sender idling after a full drain, and only the receiver idling.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_on = (phase == 1) || (phase == 2);
      recv_idle_on = (phase == 1) || (phase == 3);
      if (phase == 2) drain_results();
      phase_end = bytes_sent + 150;
      while (bytes_sent < phase_end) send_random_message();
    end

    drain_results();
    // A stray result would still pass through the byte register and the result
    // register; the extra wait gives the checker time to catch it.
    repeat (8) @(posedge clk_i);

    $display("Sent %0d stream bytes: opening corner cases, then random messages", bytes_sent);
    $display("under four pacing mixes; %0d results compared field by field.", checked);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/nbd_pkg.sv
hdl/nbd_in_if.sv
hdl/nbd_out_if.sv
hdl/nbd_parser.sv
hdl/nodeid_binary_decoder.sv
verif/nbd_checker.sv
verif/tb.sv
